[rtl/inode_reference_cache_assert.svh]
// assertion macros for the inode reference cache
// no dependencies; included by inode_reference_cache, which checks itself
`ifndef INODE_REFERENCE_CACHE_ASSERT_SVH
`define INODE_REFERENCE_CACHE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define IRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irc assertion failed");
// next-cycle implication, checked out of reset
`define IRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irc assertion failed");
`else
`define IRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IRC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/irc_pkg.sv]
// shared constants, types and codes of the inode reference cache
// no dependencies; imported by irc_slot_table and inode_reference_cache
package irc_pkg;

    // table geometry
    localparam int NUM_SLOTS        = 64;
    localparam int NUM_DEVICES      = 4;
    // must be a power of two: the block/offset split is a shift and a mask
    localparam int INODES_PER_BLOCK = 8;

    localparam int SLOT_IW  = $clog2(NUM_SLOTS);
    localparam int SCAN_W   = $clog2(NUM_SLOTS + 1);

    // field widths
    localparam int DEV_W    = 2;
    localparam int INO_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int CNT_W    = 16;
    localparam int BLK_W    = 32;
    localparam int OFF_W    = 3;
    localparam int START_W  = 31;
    localparam int NUM_CFG  = 4;
    localparam int CFG_IW   = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // request codes
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_ALLOC     = 3'd1,
        ST_FULL      = 3'd2,
        ST_HELD      = 3'd3,
        ST_FREED     = 3'd4,
        ST_WRITEBACK = 3'd5,
        ST_BADREL    = 3'd6,
        ST_OVERFLOW  = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL,
        S_LOC1,
        S_LOC2
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [DEV_W-1:0] dev;
        logic [INO_W-1:0] inode;
    } t_slot_entry;

    typedef struct packed {
        logic               en;
        logic [SLOT_IW-1:0] addr;
        logic               held;
        t_slot_entry        entry;
    } t_slot_wr;

endpackage

[rtl/inode_reference_cache.sv]
// Inode reference cache top: sequencer, shared slot compare and block locate.
// Acquire: one slot compared per cycle; a hit answers once it is compared, a miss once
// the whole table is scanned, as full or as an allocate with the two-step locate.
// Release: a read of the slot, then S_LOC1 and S_LOC2 for a writeback; an out-of-range slot answers from idle.
// One transaction at a time, set by the scan of the single table read port; results are
// strobed by o_done for one cycle and cannot be stalled. Reset empties every slot at once.
`include "inode_reference_cache_assert.svh"
module inode_reference_cache import irc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [DEV_W-1:0]   i_device_id,
    input  logic [INO_W-1:0]   i_inode_number,
    input  logic [SLOT_W-1:0]  i_slot_index,
    input  logic               i_dirty_flag,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [START_W-1:0] i_cfg_data,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [SLOT_W-1:0]  o_slot_out,
    output logic [BLK_W-1:0]   o_disk_block,
    output logic [OFF_W-1:0]   o_block_offset,
    output logic [CNT_W-1:0]   o_ref_count_out
);

    // control registers
    t_state              r_state, n_state;
    logic [SCAN_W-1:0]   r_idx, n_idx;
    logic                r_rd_vld, n_rd_vld;
    logic                r_free_found, n_free_found;
    logic                r_done, n_done;
    logic [START_W-1:0]  r_itable_start [NUM_CFG];

    // payload registers
    logic [SLOT_IW-1:0]  r_rd_idx, n_rd_idx;
    logic [SLOT_IW-1:0]  r_free_idx, n_free_idx;
    logic [DEV_W-1:0]    r_req_dev, n_req_dev;
    logic [INO_W-1:0]    r_req_ino, n_req_ino;
    logic [SLOT_W-1:0]   r_rel_slot, n_rel_slot;
    logic                r_dirty, n_dirty;
    logic [DEV_W-1:0]    r_loc_dev, n_loc_dev;
    logic [INO_W-1:0]    r_loc_ino, n_loc_ino;
    logic [INO_W-1:0]    r_n, n_n;
    logic [BLK_W-1:0]    r_start, n_start;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [BLK_W-1:0]    r_blk, n_blk;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // table port
    logic                rd_en;
    logic [SLOT_IW-1:0]  rd_addr;
    t_slot_wr            tbl_wr;
    t_slot_entry         rd_entry;
    logic                rd_held;

    logic                accept;
    logic                scan_hit;
    logic [CNT_W-1:0]    dec_cnt;

    irc_slot_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_wr       (tbl_wr),
        .o_rd_entry (rd_entry),
        .o_rd_held  (rd_held)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // shared compare of the slot just read against the request
    assign scan_hit = rd_held && (rd_entry.dev == r_req_dev) && (rd_entry.inode == r_req_ino);
    assign dec_cnt  = rd_entry.count - CNT_W'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                r_itable_start[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_itable_start[i_cfg_index] <= i_cfg_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rd_vld     <= n_rd_vld;
            r_free_found <= n_free_found;
            r_done       <= n_done;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_free_idx <= n_free_idx;
        r_req_dev  <= n_req_dev;
        r_req_ino  <= n_req_ino;
        r_rel_slot <= n_rel_slot;
        r_dirty    <= n_dirty;
        r_loc_dev  <= n_loc_dev;
        r_loc_ino  <= n_loc_ino;
        r_n        <= n_n;
        r_start    <= n_start;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_blk      <= n_blk;
        r_off      <= n_off;
        r_cnt      <= n_cnt;
    end

    // sequencer: next state, table access and result
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_free_found = r_free_found;
        n_done       = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_free_idx   = r_free_idx;
        n_req_dev    = r_req_dev;
        n_req_ino    = r_req_ino;
        n_rel_slot   = r_rel_slot;
        n_dirty      = r_dirty;
        n_loc_dev    = r_loc_dev;
        n_loc_ino    = r_loc_ino;
        n_n          = r_n;
        n_start      = r_start;
        n_status     = r_status;
        n_slot       = r_slot;
        n_blk        = r_blk;
        n_off        = r_off;
        n_cnt        = r_cnt;
        rd_en        = 1'b0;
        rd_addr      = r_idx[SLOT_IW-1:0];
        tbl_wr       = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req_dev  = i_device_id;
                    n_req_ino  = i_inode_number;
                    n_rel_slot = i_slot_index;
                    n_dirty    = i_dirty_flag;
                    if (i_req_type == REQ_ACQUIRE) begin
                        n_idx        = '0;
                        n_free_found = 1'b0;
                        n_state      = S_SCAN;
                    end else if (32'(i_slot_index) >= NUM_SLOTS) begin
                        // slot beyond the table
                        n_status = ST_BADREL;
                        n_slot   = i_slot_index;
                        n_cnt    = '0;
                        n_blk    = '0;
                        n_off    = '0;
                        n_done   = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = SLOT_IW'(i_slot_index);
                        n_state = S_REL;
                    end
                end
            end

            S_SCAN: begin
                // issue the next read while comparing the previous one
                if (r_idx < SCAN_W'(NUM_SLOTS)) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[SLOT_IW-1:0];
                    n_idx    = r_idx + SCAN_W'(1);
                end
                if (r_rd_vld) begin
                    if (scan_hit) begin
                        n_slot = SLOT_W'(r_rd_idx);
                        n_blk  = '0;
                        n_off  = '0;
                        if (rd_entry.count == COUNT_MAX) begin
                            n_status = ST_OVERFLOW;
                            n_cnt    = rd_entry.count;
                        end else begin
                            n_status           = ST_HIT;
                            n_cnt              = rd_entry.count + CNT_W'(1);
                            tbl_wr.en          = 1'b1;
                            tbl_wr.addr        = r_rd_idx;
                            tbl_wr.held        = 1'b1;
                            tbl_wr.entry       = rd_entry;
                            tbl_wr.entry.count = rd_entry.count + CNT_W'(1);
                        end
                        n_rd_vld = 1'b0;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!rd_held && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                end else if (r_idx == SCAN_W'(NUM_SLOTS)) begin
                    // scan finished without a hit
                    if (r_free_found) begin
                        tbl_wr.en          = 1'b1;
                        tbl_wr.addr        = r_free_idx;
                        tbl_wr.held        = 1'b1;
                        tbl_wr.entry.count = CNT_W'(1);
                        tbl_wr.entry.dev   = r_req_dev;
                        tbl_wr.entry.inode = r_req_ino;
                        n_status  = ST_ALLOC;
                        n_slot    = SLOT_W'(r_free_idx);
                        n_cnt     = CNT_W'(1);
                        n_loc_dev = r_req_dev;
                        n_loc_ino = r_req_ino;
                        n_state   = S_LOC1;
                    end else begin
                        n_status = ST_FULL;
                        n_slot   = '0;
                        n_cnt    = '0;
                        n_blk    = '0;
                        n_off    = '0;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end

            S_REL: begin
                n_slot = r_rel_slot;
                n_blk  = '0;
                n_off  = '0;
                if (!rd_held) begin
                    n_status = ST_BADREL;
                    n_cnt    = '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    tbl_wr.en          = 1'b1;
                    tbl_wr.addr        = SLOT_IW'(r_rel_slot);
                    tbl_wr.held        = (dec_cnt != '0);
                    tbl_wr.entry       = rd_entry;
                    tbl_wr.entry.count = dec_cnt;
                    n_cnt              = dec_cnt;
                    if (dec_cnt != '0) begin
                        n_status = ST_HELD;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_dirty) begin
                        n_status  = ST_WRITEBACK;
                        n_loc_dev = rd_entry.dev;
                        n_loc_ino = rd_entry.inode;
                        n_state   = S_LOC1;
                    end else begin
                        n_status = ST_FREED;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end

            S_LOC1: begin
                // inode numbers count from one; device table start
                n_n = r_loc_ino - INO_W'(1);
                if (32'(r_loc_dev) < NUM_DEVICES) begin
                    n_start = {1'b0, r_itable_start[r_loc_dev]};
                end else begin
                    n_start = '0;
                end
                n_state = S_LOC2;
            end

            S_LOC2: begin
                n_blk   = BLK_W'(r_n / INODES_PER_BLOCK) + r_start;
                n_off   = OFF_W'(r_n % INODES_PER_BLOCK);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot_out      = r_slot;
    assign o_disk_block    = r_blk;
    assign o_block_offset  = r_off;
    assign o_ref_count_out = r_cnt;

    // a result is only strobed once the sequencer is back at rest
    `IRC_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    // an accepted acquire always goes into the scan
    `IRC_ASSERT_NXT(a_acq_scan, i_clk, i_rst_n, accept && (i_req_type == REQ_ACQUIRE), r_state == S_SCAN)
    // the scan counter never runs past the table
    `IRC_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= SCAN_W'(NUM_SLOTS))
    // a newly claimed slot carries one reference
    `IRC_ASSERT_IMP(a_alloc_one, i_clk, i_rst_n, r_done && (r_status == ST_ALLOC), r_cnt == CNT_W'(1))
    // disk location is only reported for a load or a writeback
    `IRC_ASSERT_IMP(a_loc_zero, i_clk, i_rst_n, r_done && (r_status != ST_ALLOC) && (r_status != ST_WRITEBACK), (r_blk == '0) && (r_off == '0))

endmodule

[rtl/irc_slot_table.sv]
// slot table: entry memory with one write and one registered read port,
// plus a held flag per slot cleared by reset; depends on irc_pkg
module irc_slot_table import irc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [SLOT_IW-1:0] i_rd_addr,
    input  t_slot_wr           i_wr,
    output t_slot_entry        o_rd_entry,
    output logic               o_rd_held
);

    t_slot_entry             r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    r_held;
    t_slot_entry             r_rd_entry;
    logic                    r_rd_held;

    // entry memory, written at one address and read at another
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    // held flags: a slot with a nonzero count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_rd_held <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_held[i_wr.addr] <= i_wr.held;
            end
            if (i_rd_en) begin
                r_rd_held <= r_held[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_held  = r_rd_held;

endmodule

[test/inode_reference_cache_test.sv]
// self-checking testbench for inode_reference_cache: directed and random acquire/release traffic
// depends on irc_pkg and the inode_reference_cache rtl; predicts every result in its own slot table
`timescale 1ns / 1ps

module inode_reference_cache_test;
    import irc_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [DEV_W-1:0]  dev;
        logic [INO_W-1:0]  ino;
        logic [SLOT_W-1:0] slot;
        logic              dirty;
    } t_inode_request;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [BLK_W-1:0]  block;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
    } t_cache_answer;

    localparam int POOL_SIZE = 20;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_req_type = REQ_ACQUIRE;
    logic [DEV_W-1:0]   i_device_id = '0;
    logic [INO_W-1:0]   i_inode_number = '0;
    logic [SLOT_W-1:0]  i_slot_index = '0;
    logic               i_dirty_flag = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]  i_cfg_index = '0;
    logic [START_W-1:0] i_cfg_data = '0;
    logic               o_done;
    logic [2:0]         o_status;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [BLK_W-1:0]   o_disk_block;
    logic [OFF_W-1:0]   o_block_offset;
    logic [CNT_W-1:0]   o_ref_count_out;

    // predicted slot table and inode table starts
    logic [CNT_W-1:0]   slot_count [NUM_SLOTS] = '{default: '0};
    logic [DEV_W-1:0]   slot_dev [NUM_SLOTS] = '{default: '0};
    logic [INO_W-1:0]   slot_ino [NUM_SLOTS] = '{default: '0};
    logic [START_W-1:0] table_start [NUM_CFG] = '{default: '0};

    t_inode_request request_queue [$];
    t_cache_answer  expected_answers [$];

    // driver and monitor state
    t_inode_request next_req;
    t_inode_request sampled_req;
    t_cache_answer  observed;
    t_cache_answer  predicted;
    logic           start_taken = 1'b0;
    logic           launch = 1'b0;
    logic           idle_enable = 1'b1;
    logic           calm_stretch = 1'b0;
    int unsigned    idle_left = 0;
    int             mismatch_count = 0;

    logic [DEV_W-1:0] pool_dev [POOL_SIZE];
    logic [INO_W-1:0] pool_ino [POOL_SIZE];

    inode_reference_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_device_id     (i_device_id),
        .i_inode_number  (i_inode_number),
        .i_slot_index    (i_slot_index),
        .i_dirty_flag    (i_dirty_flag),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot_out      (o_slot_out),
        .o_disk_block    (o_disk_block),
        .o_block_offset  (o_block_offset),
        .o_ref_count_out (o_ref_count_out)
    );

    always #5 i_clk = ~i_clk;

    // disk block and offset of an inode on a device
    function automatic void inode_location(input logic [DEV_W-1:0] dev,
                                           input logic [INO_W-1:0] ino,
                                           output logic [BLK_W-1:0] block,
                                           output logic [OFF_W-1:0] offset);
        logic [INO_W-1:0] index0;
        logic [BLK_W-1:0] base;
        // inode zero wraps to the top of the range
        index0 = ino - 1'b1;
        base = (dev < NUM_DEVICES) ? BLK_W'(table_start[dev]) : '0;
        block = index0 / INODES_PER_BLOCK + base;
        offset = OFF_W'(index0 % INODES_PER_BLOCK);
    endfunction

    // apply one transaction to the predicted table and return its answer
    function automatic t_cache_answer resolve_request(input t_inode_request r);
        t_cache_answer res;
        logic          found;
        res = '0;
        found = 1'b0;
        if (r.kind == REQ_ACQUIRE) begin
            // held slot with the same tags first
            for (int k = 0; k < NUM_SLOTS && !found; k++) begin
                if (slot_count[k] != 0 && slot_dev[k] == r.dev && slot_ino[k] == r.ino) begin
                    found = 1'b1;
                    res.slot = SLOT_W'(k);
                    if (slot_count[k] == COUNT_MAX) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        slot_count[k] = slot_count[k] + 1'b1;
                        res.status = ST_HIT;
                    end
                    res.count = slot_count[k];
                end
            end
            // then the lowest free slot
            for (int k = 0; k < NUM_SLOTS && !found; k++) begin
                if (slot_count[k] == 0) begin
                    found = 1'b1;
                    slot_count[k] = CNT_W'(1);
                    slot_dev[k] = r.dev;
                    slot_ino[k] = r.ino;
                    res.slot = SLOT_W'(k);
                    res.count = CNT_W'(1);
                    res.status = ST_ALLOC;
                    inode_location(r.dev, r.ino, res.block, res.offset);
                end
            end
            if (!found) begin
                res.status = ST_FULL;
            end
        end else begin
            res.slot = r.slot;
            if (r.slot >= NUM_SLOTS || slot_count[r.slot] == 0) begin
                res.status = ST_BADREL;
            end else begin
                slot_count[r.slot] = slot_count[r.slot] - 1'b1;
                res.count = slot_count[r.slot];
                if (res.count != 0) begin
                    res.status = ST_HELD;
                end else if (r.dirty) begin
                    res.status = ST_WRITEBACK;
                    inode_location(slot_dev[r.slot], slot_ino[r.slot], res.block, res.offset);
                end else begin
                    res.status = ST_FREED;
                end
            end
        end
        return res;
    endfunction

    // random content for every field
    function automatic t_inode_request noise_request();
        t_inode_request r;
        r.kind = 1'($urandom_range(0, 1));
        r.dev = DEV_W'($urandom);
        r.ino = $urandom;
        r.slot = SLOT_W'($urandom);
        r.dirty = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic push_acquire(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino);
        t_inode_request r;
        r = noise_request();
        r.kind = REQ_ACQUIRE;
        r.dev = dev;
        r.ino = ino;
        request_queue.push_back(r);
    endtask

    task automatic push_release(input logic [SLOT_W-1:0] slot, input logic dirty);
        t_inode_request r;
        r = noise_request();
        r.kind = REQ_RELEASE;
        r.slot = slot;
        r.dirty = dirty;
        request_queue.push_back(r);
    endtask

    // block idle with nothing pending or in flight, ends on a rising edge
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || start || launch || busy
               || expected_answers.size() != 0);
        repeat (8) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // write all four table starts while idle
    task automatic load_table_starts(input logic [START_W-1:0] s0, input logic [START_W-1:0] s1,
                                     input logic [START_W-1:0] s2, input logic [START_W-1:0] s3);
        logic [START_W-1:0] plan [NUM_CFG];
        plan = '{s0, s1, s2, s3};
        wait_quiet();
        for (int k = 0; k < NUM_CFG; k++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_IW'(k);
            i_cfg_data <= plan[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random traffic: mostly tags from a small pool so hits and releases land on held slots
    task automatic run_random_phase(input int count, input int acquire_pct, input int fresh_pct);
        logic [DEV_W-1:0] dev;
        logic [INO_W-1:0] ino;
        int               pick;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_dev[k] = DEV_W'($urandom);
            pool_ino[k] = $urandom_range(1, 200);
        end
        pool_dev[0] = 2'd3;
        pool_ino[0] = '1;
        pool_ino[1] = '0;
        pool_ino[2] = 1;
        // same inode on another device
        pool_ino[3] = pool_ino[4];
        pool_dev[3] = pool_dev[4] + 1'b1;
        pool_ino[5] = $urandom;
        repeat (count) begin
            if ($urandom_range(0, 99) < acquire_pct) begin
                if ($urandom_range(0, 99) < fresh_pct) begin
                    dev = DEV_W'($urandom);
                    pick = $urandom_range(0, 9);
                    ino = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
                end else begin
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    dev = pool_dev[pick];
                    ino = pool_ino[pick];
                end
                push_acquire(dev, ino);
            end else if ($urandom_range(0, 9) < 7) begin
                push_release(SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end else begin
                push_release(SLOT_W'($urandom), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // driver: next transaction or a random idle burst at each falling edge
    always @(negedge i_clk) begin
        if (!start || start_taken) begin
            launch = 1'b0;
            if (idle_left != 0) begin
                idle_left = idle_left - 1;
            end else if (idle_enable && !calm_stretch && $urandom_range(0, 3) == 0) begin
                // start an idle burst; idle_left holds what remains of it
                idle_left = $urandom_range(0, 4);
            end else if (request_queue.size() != 0) begin
                next_req = request_queue.pop_front();
                launch = 1'b1;
                if ($urandom_range(0, 47) == 0) begin
                    calm_stretch = !calm_stretch;
                end
            end
            // fields carry noise while start is low
            if (!launch) begin
                next_req = noise_request();
            end
            start <= launch;
            i_req_type <= next_req.kind;
            i_device_id <= next_req.dev;
            i_inode_number <= next_req.ino;
            i_slot_index <= next_req.slot;
            i_dirty_flag <= next_req.dirty;
        end
    end

    // monitor: check results, track config writes, predict accepted transactions
    always @(posedge i_clk) begin
        start_taken = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                observed = '{t_status'(o_status), o_slot_out, o_disk_block, o_block_offset,
                             o_ref_count_out};
                if (expected_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result with nothing expected: status %0d slot %0d",
                                 $realtime, o_status, o_slot_out);
                    end
                end else begin
                    predicted = expected_answers.pop_front();
                    if (observed.status !== predicted.status || observed.slot !== predicted.slot
                        || observed.block !== predicted.block
                        || observed.offset !== predicted.offset
                        || observed.count !== predicted.count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: mismatch: expected status %0d slot %0d block %h ",
                                      "offset %0d count %0d, got status %0d slot %0d block %h ",
                                      "offset %0d count %0d"}, $realtime,
                                     predicted.status, predicted.slot, predicted.block,
                                     predicted.offset, predicted.count,
                                     observed.status, observed.slot, observed.block,
                                     observed.offset, observed.count);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                table_start[i_cfg_index] = i_cfg_data;
            end
            if (start && !busy) begin
                start_taken = 1'b1;
                sampled_req = '{i_req_type, i_device_id, i_inode_number, i_slot_index,
                                i_dirty_flag};
                expected_answers.push_back(resolve_request(sampled_req));
            end
        end
    end

    // stimulus phases
    initial begin : stimulus
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, table starts at their reset value
        push_acquire(2'd0, 32'd1);
        push_acquire(2'd0, 32'd1);
        push_acquire(2'd1, 32'd1);
        push_acquire(2'd3, 32'd0);
        push_acquire(2'd2, '1);
        push_acquire(2'd0, 32'd9);
        push_release(SLOT_W'(0), 1'b1);
        push_release(SLOT_W'(0), 1'b1);
        push_release(SLOT_W'(0), 1'b0);
        push_release(SLOT_W'(63), 1'b1);
        push_release(SLOT_W'(1), 1'b0);
        push_acquire(2'd3, 32'd8);
        push_release(SLOT_W'(2), 1'b1);

        // directed, largest table starts
        load_table_starts('1, '1, '1, '1);
        push_acquire(2'd3, '1);
        push_release(SLOT_W'(1), 1'b1);
        push_release(SLOT_W'(3), 1'b1);
        push_release(SLOT_W'(4), 1'b1);
        push_release(SLOT_W'(0), 1'b1);
        push_release(SLOT_W'(0), 1'b1);

        // random phases, some filling the table, some draining it
        load_table_starts(START_W'($urandom), START_W'($urandom), START_W'($urandom),
                          START_W'($urandom));
        run_random_phase(320, 60, 20);
        load_table_starts('1, '1, '1, '1);
        run_random_phase(320, 85, 50);
        load_table_starts('0, '0, '0, '0);
        run_random_phase(320, 35, 20);
        load_table_starts('0, '1, START_W'($urandom), START_W'($urandom));
        run_random_phase(320, 90, 60);
        load_table_starts(START_W'($urandom), START_W'($urandom), START_W'($urandom),
                          START_W'($urandom));
        run_random_phase(320, 50, 10);
        load_table_starts(START_W'($urandom), '1, '0, START_W'($urandom));
        // no idling from here on
        idle_enable = 1'b0;
        run_random_phase(320, 45, 25);

        // release every reference still held
        wait_quiet();
        for (int k = 0; k < NUM_SLOTS; k++) begin
            repeat (slot_count[k]) push_release(SLOT_W'(k), 1'($urandom_range(0, 1)));
        end

        wait_quiet();
        repeat (80) @(negedge i_clk);
        mismatch_count += expected_answers.size();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[inode_reference_cache.f]
+incdir+rtl
rtl/irc_pkg.sv
rtl/irc_slot_table.sv
rtl/inode_reference_cache.sv
test/inode_reference_cache_test.sv
